// ===== sv/dwfs_pkg.sv =====
// shared types, codes and constants for the dirty window framebuffer scanout unit
package dwfs_pkg;

  localparam int DEFAULT_MAX_WIDTH  = 320;
  localparam int DEFAULT_MAX_HEIGHT = 320;

  localparam int COORD_W    = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int BCNT_W     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_OFFSET    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EIGHTEEN_BIT  = 3'd4;

  localparam logic [8:0] RST_FRAME_WIDTH  = 9'd240;
  localparam logic [8:0] RST_FRAME_HEIGHT = 9'd320;
  localparam logic [8:0] EMPTY_MIN        = 9'd511;

  localparam logic [7:0] CMD_CASET = 8'h2A;
  localparam logic [7:0] CMD_PASET = 8'h2B;
  localparam logic [7:0] CMD_RAMWR = 8'h2C;

  // header byte positions
  localparam logic [BCNT_W-1:0] HB_CASET   = 4'd0;
  localparam logic [BCNT_W-1:0] HB_CS_HI   = 4'd1;
  localparam logic [BCNT_W-1:0] HB_CS_LO   = 4'd2;
  localparam logic [BCNT_W-1:0] HB_CE_HI   = 4'd3;
  localparam logic [BCNT_W-1:0] HB_CE_LO   = 4'd4;
  localparam logic [BCNT_W-1:0] HB_PASET   = 4'd5;
  localparam logic [BCNT_W-1:0] HB_RS_HI   = 4'd6;
  localparam logic [BCNT_W-1:0] HB_RS_LO   = 4'd7;
  localparam logic [BCNT_W-1:0] HB_RE_HI   = 4'd8;
  localparam logic [BCNT_W-1:0] HB_RE_LO   = 4'd9;
  localparam logic [BCNT_W-1:0] HB_RAMWR   = 4'd10;

  // pixel byte positions
  localparam logic [BCNT_W-1:0] PB_FIRST   = 4'd0;
  localparam logic [BCNT_W-1:0] PB_SECOND  = 4'd1;
  localparam logic [BCNT_W-1:0] PB_THIRD   = 4'd2;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_FLUSH = 2'd1,
    OP_PIXEL = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_READ,
    ST_WRITE,
    ST_HDR,
    ST_PIX
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic latch;
    logic calc;
    logic rd;
    logic wr_draw;
    logic flush_start;
    logic byte_adv;
    logic scan_adv;
  } dwfs_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic draw_ok;
    logic trk_empty;
    logic scan_act;
    logic byte_last;
    op_t  op;
  } dwfs_stat_t;

endpackage

// ===== sv/dwfs_ctrl.sv =====
// controller state machine sequencing clear, draw, flush and pixel scan-out
module dwfs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  dwfs_pkg::dwfs_stat_t stat,
  output dwfs_pkg::dwfs_cmd_t  cmd
);

  dwfs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dwfs_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dwfs_pkg::ST_CLEAR: begin
        if (stat.clr_last) state_nxt = dwfs_pkg::ST_IDLE;
      end
      dwfs_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = dwfs_pkg::ST_CALC;
      end
      dwfs_pkg::ST_CALC: begin
        case (stat.op)
          dwfs_pkg::OP_DRAW:
            state_nxt = stat.draw_ok ? dwfs_pkg::ST_READ : dwfs_pkg::ST_IDLE;
          dwfs_pkg::OP_FLUSH:
            state_nxt = stat.trk_empty ? dwfs_pkg::ST_IDLE : dwfs_pkg::ST_HDR;
          dwfs_pkg::OP_PIXEL:
            state_nxt = stat.scan_act ? dwfs_pkg::ST_READ : dwfs_pkg::ST_IDLE;
          default:
            state_nxt = dwfs_pkg::ST_IDLE;
        endcase
      end
      dwfs_pkg::ST_READ: begin
        state_nxt = (stat.op == dwfs_pkg::OP_DRAW) ? dwfs_pkg::ST_WRITE : dwfs_pkg::ST_PIX;
      end
      dwfs_pkg::ST_WRITE: begin
        state_nxt = dwfs_pkg::ST_IDLE;
      end
      dwfs_pkg::ST_HDR, dwfs_pkg::ST_PIX: begin
        if (out_tready && stat.byte_last) state_nxt = dwfs_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = dwfs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready       = (state_r == dwfs_pkg::ST_IDLE);
    out_tvalid      = (state_r == dwfs_pkg::ST_HDR) || (state_r == dwfs_pkg::ST_PIX);
    cmd             = '0;
    cmd.clr_step    = (state_r == dwfs_pkg::ST_CLEAR);
    cmd.latch       = (state_r == dwfs_pkg::ST_IDLE) && in_tvalid;
    cmd.calc        = (state_r == dwfs_pkg::ST_CALC);
    cmd.rd          = (state_r == dwfs_pkg::ST_READ);
    cmd.wr_draw     = (state_r == dwfs_pkg::ST_WRITE);
    cmd.flush_start = (state_r == dwfs_pkg::ST_CALC) && (stat.op == dwfs_pkg::OP_FLUSH)
                      && !stat.trk_empty;
    cmd.byte_adv    = out_tvalid && out_tready;
    cmd.scan_adv    = (state_r == dwfs_pkg::ST_PIX) && out_tready && stat.byte_last;
  end

endmodule

// ===== sv/dwfs_dpath.sv =====
// datapath: config registers, pixel store, dirty tracker, scan position and byte mux
module dwfs_dpath #(
  parameter int MAX_WIDTH  = dwfs_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = dwfs_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [dwfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dwfs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [47:0]                      in_tdata,
  input  logic [1:0]                       in_tuser,
  output logic [7:0]                       out_tdata,
  output logic [1:0]                       out_tuser,
  output logic                             out_tlast,
  input  dwfs_pkg::dwfs_cmd_t              cmd,
  output dwfs_pkg::dwfs_stat_t             stat
);

  localparam int STORE  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(STORE);
  localparam int IDX_W  = $clog2(511 * MAX_WIDTH + 512);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE - 1);
  localparam logic [IDX_W-1:0]  STORE_IDX = IDX_W'(STORE);
  localparam logic [8:0]        MAXW9     = 9'(MAX_WIDTH);
  localparam logic [8:0]        MAXH9     = 9'(MAX_HEIGHT);

  logic [8:0]  fw_r, fh_r;
  logic [7:0]  co_r, ro_r;
  logic        e18_r;

  dwfs_pkg::op_t op_r;
  logic [15:0] x_r, y_r, color_r;

  logic [8:0]  cmin_r, rmin_r, cmax_r, rmax_r;
  logic        scan_act_r;
  logic [8:0]  scol_r, srow_r, wb0_r, wb1_r, wb2_r;
  logic [9:0]  hcs_r, hce_r, hrs_r, hre_r;

  logic [IDX_W-1:0]  idx_r;
  logic              oob_r;
  logic [15:0]       rdata_r;
  logic [dwfs_pkg::BCNT_W-1:0] bcnt_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  logic [15:0] mem [STORE];

  logic [8:0]  eff_w, eff_h;
  logic [8:0]  row_sel, col_sel;
  logic [17:0] prod;
  logic [IDX_W-1:0] idx_calc;
  logic        wr_en;
  logic [15:0] pix_c;
  logic        win_end;
  logic        byte_last;

  assign eff_w = (fw_r > MAXW9) ? MAXW9 : fw_r;
  assign eff_h = (fh_r > MAXH9) ? MAXH9 : fh_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= dwfs_pkg::RST_FRAME_WIDTH;
      fh_r  <= dwfs_pkg::RST_FRAME_HEIGHT;
      co_r  <= '0;
      ro_r  <= '0;
      e18_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        dwfs_pkg::REG_FRAME_WIDTH:   fw_r  <= cfg_data;
        dwfs_pkg::REG_FRAME_HEIGHT:  fh_r  <= cfg_data;
        dwfs_pkg::REG_COLUMN_OFFSET: co_r  <= cfg_data[7:0];
        dwfs_pkg::REG_ROW_OFFSET:    ro_r  <= cfg_data[7:0];
        dwfs_pkg::REG_EIGHTEEN_BIT:  e18_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= dwfs_pkg::op_t'(in_tuser);
      x_r     <= in_tdata[15:0];
      y_r     <= in_tdata[31:16];
      color_r <= in_tdata[47:32];
    end
  end

  // raster index
  assign row_sel  = (op_r == dwfs_pkg::OP_DRAW) ? y_r[8:0] : srow_r;
  assign col_sel  = (op_r == dwfs_pkg::OP_DRAW) ? x_r[8:0] : scol_r;
  assign prod     = row_sel * eff_w;
  assign idx_calc = IDX_W'(prod) + IDX_W'(col_sel);

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      idx_r <= idx_calc;
      oob_r <= (idx_calc >= STORE_IDX);
    end
  end

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step && (clr_cnt_r != LAST_ADDR)) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign wr_en = cmd.wr_draw && (rdata_r != color_r);

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem[idx_r[ADDR_W-1:0]] <= color_r;
    end
    if (cmd.rd) begin
      rdata_r <= mem[idx_r[ADDR_W-1:0]];
    end
  end

  // dirty tracker
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmin_r <= dwfs_pkg::EMPTY_MIN;
      rmin_r <= dwfs_pkg::EMPTY_MIN;
      cmax_r <= '0;
      rmax_r <= '0;
    end else if (cmd.flush_start) begin
      cmin_r <= dwfs_pkg::EMPTY_MIN;
      rmin_r <= dwfs_pkg::EMPTY_MIN;
      cmax_r <= '0;
      rmax_r <= '0;
    end else if (wr_en) begin
      if (x_r[8:0] < cmin_r) cmin_r <= x_r[8:0];
      if (y_r[8:0] < rmin_r) rmin_r <= y_r[8:0];
      if (x_r[8:0] > cmax_r) cmax_r <= x_r[8:0];
      if (y_r[8:0] > rmax_r) rmax_r <= y_r[8:0];
    end
  end

  // header coordinates
  always_ff @(posedge clk) begin
    if (cmd.flush_start) begin
      hcs_r <= 10'(cmin_r) + 10'(co_r);
      hce_r <= 10'(cmax_r) + 10'(co_r);
      hrs_r <= 10'(rmin_r) + 10'(ro_r);
      hre_r <= 10'(rmax_r) + 10'(ro_r);
    end
  end

  assign win_end = (scol_r >= wb1_r) && (srow_r >= wb2_r);

  // scan window and position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_act_r <= 1'b0;
      scol_r     <= '0;
      srow_r     <= '0;
      wb0_r      <= '0;
      wb1_r      <= '0;
      wb2_r      <= '0;
    end else if (cmd.flush_start) begin
      scan_act_r <= 1'b1;
      scol_r     <= cmin_r;
      srow_r     <= rmin_r;
      wb0_r      <= cmin_r;
      wb1_r      <= cmax_r;
      wb2_r      <= rmax_r;
    end else if (cmd.scan_adv) begin
      if (scol_r >= wb1_r) begin
        scol_r <= wb0_r;
        if (srow_r >= wb2_r) begin
          scan_act_r <= 1'b0;
        end else begin
          srow_r <= srow_r + 1'b1;
        end
      end else begin
        scol_r <= scol_r + 1'b1;
      end
    end
  end

  // byte counter
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      bcnt_r <= '0;
    end else if (cmd.byte_adv) begin
      bcnt_r <= bcnt_r + 1'b1;
    end
  end

  assign pix_c = oob_r ? 16'h0000 : rdata_r;

  always_comb begin
    out_tdata    = '0;
    out_tuser    = '0;
    byte_last    = 1'b0;
    if (op_r == dwfs_pkg::OP_FLUSH) begin
      out_tuser[0] = 1'b1;
      case (bcnt_r)
        dwfs_pkg::HB_CASET: begin
          out_tdata    = dwfs_pkg::CMD_CASET;
          out_tuser[0] = 1'b0;
        end
        dwfs_pkg::HB_CS_HI: out_tdata = 8'(hcs_r[9:8]);
        dwfs_pkg::HB_CS_LO: out_tdata = hcs_r[7:0];
        dwfs_pkg::HB_CE_HI: out_tdata = 8'(hce_r[9:8]);
        dwfs_pkg::HB_CE_LO: out_tdata = hce_r[7:0];
        dwfs_pkg::HB_PASET: begin
          out_tdata    = dwfs_pkg::CMD_PASET;
          out_tuser[0] = 1'b0;
        end
        dwfs_pkg::HB_RS_HI: out_tdata = 8'(hrs_r[9:8]);
        dwfs_pkg::HB_RS_LO: out_tdata = hrs_r[7:0];
        dwfs_pkg::HB_RE_HI: out_tdata = 8'(hre_r[9:8]);
        dwfs_pkg::HB_RE_LO: out_tdata = hre_r[7:0];
        dwfs_pkg::HB_RAMWR: begin
          out_tdata    = dwfs_pkg::CMD_RAMWR;
          out_tuser[0] = 1'b0;
          byte_last    = 1'b1;
        end
        default: out_tdata = '0;
      endcase
    end else begin
      out_tuser[0] = 1'b1;
      if (e18_r) begin
        byte_last = (bcnt_r == dwfs_pkg::PB_THIRD);
        case (bcnt_r)
          dwfs_pkg::PB_FIRST:  out_tdata = {pix_c[15:11], 3'b000};
          dwfs_pkg::PB_SECOND: out_tdata = {pix_c[10:5], 2'b00};
          dwfs_pkg::PB_THIRD:  out_tdata = {pix_c[4:0], 3'b000};
          default:             out_tdata = '0;
        endcase
      end else begin
        byte_last = (bcnt_r == dwfs_pkg::PB_SECOND);
        case (bcnt_r)
          dwfs_pkg::PB_FIRST:  out_tdata = pix_c[15:8];
          dwfs_pkg::PB_SECOND: out_tdata = pix_c[7:0];
          default:             out_tdata = '0;
        endcase
      end
      out_tuser[1] = byte_last && win_end;
    end
  end

  assign out_tlast = byte_last;

  always_comb begin
    stat           = '0;
    stat.clr_last  = (clr_cnt_r == LAST_ADDR);
    stat.draw_ok   = !x_r[15] && !y_r[15] && (x_r < 16'(eff_w)) && (y_r < 16'(eff_h));
    stat.trk_empty = (cmax_r < cmin_r) || (rmax_r < rmin_r);
    stat.scan_act  = scan_act_r;
    stat.byte_last = byte_last;
    stat.op        = op_r;
  end

endmodule

// ===== sv/dirty_window_framebuffer_scanout_unit.sv =====
// top level: framebuffer with dirty rectangle tracking and panel byte scan-out
// draw: accept, index multiply, store read, then compare and write; dropped after the index multiply
// flush: accept, index multiply, then 11 bytes at one per cycle while out_tready is high; no bytes if nothing dirty
// next pixel: accept, index multiply, store read, then 2 or 3 bytes; no bytes if no scan
// one item at a time; the single-port store read and the byte serializer set the rate
// reset starts a clearing pass over all MAX_WIDTH*MAX_HEIGHT store words with in_tready low
module dirty_window_framebuffer_scanout_unit #(
  parameter int MAX_WIDTH  = dwfs_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = dwfs_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dwfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dwfs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [47:0]                     in_tdata,   // pos_x, pos_y, pixel_color
  input  logic [1:0]                      in_tuser,   // op
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // out_byte
  output logic [1:0]                      out_tuser,  // is_data, window_done
  output logic                            out_tlast
);

  dwfs_pkg::dwfs_cmd_t  cmd;
  dwfs_pkg::dwfs_stat_t stat;

  assign cfg_ready = 1'b1;

  dwfs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  dwfs_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cmd       (cmd),
    .stat      (stat)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while a word is pending");

  a_done_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tuser[0] && out_tlast))
    else $error("window done off the last data word");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input taken before clearing pass");

endmodule

// ===== tb/dwfs_scanout_checker.sv =====
// checker for the scanout unit: mirrors its state, predicts panel words and compares them
module dwfs_scanout_checker
  import dwfs_pkg::*;
#(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [47:0]           in_tdata,   // pos_x, pos_y, pixel_color
  input  logic [1:0]            in_tuser,   // op
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [7:0]            out_tdata,  // out_byte
  input  logic [1:0]            out_tuser,  // is_data, window_done
  input  logic                  out_tlast,
  output int                    mismatches,
  output int                    pending,
  output int                    words_in,
  output int                    words_out,
  output int                    windows_done
);

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  typedef struct packed {
    logic [7:0] data;
    logic       is_data;
    logic       last;
    logic       done;
  } panel_word_t;

  logic [15:0] fb_mirror [STORE_DEPTH];
  panel_word_t panel_q [$];

  int         frame_w, frame_h;
  logic [7:0] col_off, row_off;
  logic       pix18;
  int         dcmin, drmin, dcmax, drmax;
  logic       scanning;
  int         scol, srow, win_c0, win_c1, win_r1;
  int         fail_n, in_n, out_n, win_n;

  function automatic int clamp_dim(int v, int lim);
    return (v > lim) ? lim : v;
  endfunction

  task automatic push_word(logic [7:0] b, logic d, logic l, logic dn);
    panel_word_t w;
    w.data    = b;
    w.is_data = d;
    w.last    = l;
    w.done    = dn;
    panel_q.push_back(w);
  endtask

  task automatic push_coords(int a, int b);
    push_word(a[15:8], 1'b1, 1'b0, 1'b0);
    push_word(a[7:0], 1'b1, 1'b0, 1'b0);
    push_word(b[15:8], 1'b1, 1'b0, 1'b0);
    push_word(b[7:0], 1'b1, 1'b0, 1'b0);
  endtask

  task automatic clear_dirty();
    dcmin = EMPTY_MIN;
    drmin = EMPTY_MIN;
    dcmax = 0;
    drmax = 0;
  endtask

  task automatic predict_word(op_t op, logic signed [15:0] px, logic signed [15:0] py,
                              logic [15:0] color);
    int          w, h, sx, sy, idx;
    logic [15:0] c;
    logic        fin;
    w  = clamp_dim(frame_w, MAX_WIDTH);
    h  = clamp_dim(frame_h, MAX_HEIGHT);
    sx = px;
    sy = py;
    case (op)
      OP_DRAW: begin
        if (sx >= 0 && sy >= 0 && sx < w && sy < h) begin
          idx = sy * w + sx;
          if (idx < STORE_DEPTH && fb_mirror[idx] != color) begin
            fb_mirror[idx] = color;
            if (sx < dcmin) dcmin = sx;
            if (sy < drmin) drmin = sy;
            if (sx > dcmax) dcmax = sx;
            if (sy > drmax) drmax = sy;
          end
        end
      end
      OP_FLUSH: begin
        if (dcmax >= dcmin && drmax >= drmin) begin
          win_c0   = dcmin;
          win_c1   = dcmax;
          win_r1   = drmax;
          scol     = dcmin;
          srow     = drmin;
          scanning = 1'b1;
          push_word(CMD_CASET, 1'b0, 1'b0, 1'b0);
          push_coords(dcmin + col_off, dcmax + col_off);
          push_word(CMD_PASET, 1'b0, 1'b0, 1'b0);
          push_coords(drmin + row_off, drmax + row_off);
          push_word(CMD_RAMWR, 1'b0, 1'b1, 1'b0);
          clear_dirty();
        end
      end
      OP_PIXEL: begin
        if (scanning) begin
          idx = srow * w + scol;
          c   = (idx < STORE_DEPTH) ? fb_mirror[idx] : 16'h0000;
          fin = 1'b0;
          if (scol >= win_c1) begin
            scol = win_c0;
            if (srow >= win_r1) begin
              fin      = 1'b1;
              scanning = 1'b0;
            end else begin
              srow = (srow + 1) & 'h1FF;
            end
          end else begin
            scol = (scol + 1) & 'h1FF;
          end
          if (pix18) begin
            push_word({c[15:11], 3'b000}, 1'b1, 1'b0, 1'b0);
            push_word({c[10:5], 2'b00}, 1'b1, 1'b0, 1'b0);
            push_word({c[4:0], 3'b000}, 1'b1, 1'b1, fin);
          end else begin
            push_word(c[15:8], 1'b1, 1'b0, 1'b0);
            push_word(c[7:0], 1'b1, 1'b1, fin);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    panel_word_t got, want;
    if (!rst_n) begin
      foreach (fb_mirror[i]) fb_mirror[i] = 16'h0000;
      panel_q.delete();
      clear_dirty();
      scanning = 1'b0;
      scol     = 0;
      srow     = 0;
      win_c0   = 0;
      win_c1   = 0;
      win_r1   = 0;
      frame_w  = RST_FRAME_WIDTH;
      frame_h  = RST_FRAME_HEIGHT;
      col_off  = 8'd0;
      row_off  = 8'd0;
      pix18    = 1'b0;
      fail_n   = 0;
      in_n     = 0;
      out_n    = 0;
      win_n    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH:   frame_w = cfg_data;
          REG_FRAME_HEIGHT:  frame_h = cfg_data;
          REG_COLUMN_OFFSET: col_off = cfg_data[7:0];
          REG_ROW_OFFSET:    row_off = cfg_data[7:0];
          REG_EIGHTEEN_BIT:  pix18   = cfg_data[0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.data    = out_tdata;
        got.is_data = out_tuser[0];
        got.last    = out_tlast;
        got.done    = out_tuser[1];
        out_n++;
        if (got.done === 1'b1) win_n++;
        if (panel_q.size() == 0) begin
          fail_n++;
          if (fail_n <= 10)
            $display("unexpected output word %0d: byte %h is_data %b last %b done %b",
                     out_n, got.data, got.is_data, got.last, got.done);
        end else begin
          want = panel_q.pop_front();
          if (got.data !== want.data || got.is_data !== want.is_data ||
              got.last !== want.last || got.done !== want.done) begin
            fail_n++;
            if (fail_n <= 10)
              $display("output word %0d: expected byte %h is_data %b last %b done %b, got byte %h is_data %b last %b done %b",
                       out_n, want.data, want.is_data, want.last, want.done,
                       got.data, got.is_data, got.last, got.done);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        in_n++;
        predict_word(op_t'(in_tuser), in_tdata[15:0], in_tdata[31:16], in_tdata[47:32]);
      end
    end
    mismatches   <= fail_n;
    pending      <= panel_q.size();
    words_in     <= in_n;
    words_out    <= out_n;
    windows_done <= win_n;
  end

endmodule

// ===== tb/dirty_window_framebuffer_scanout_unit_tb.sv =====
// testbench top: stimulus, output back-pressure, watchdog and verdict for the scanout unit
module dirty_window_framebuffer_scanout_unit_tb;
  import dwfs_pkg::*;

  localparam int MAX_W          = DEFAULT_MAX_WIDTH;
  localparam int MAX_H          = DEFAULT_MAX_HEIGHT;
  localparam int RANDOM_ITEMS   = 350;
  localparam int QUIET_CYCLES   = 20;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [47:0]           in_tdata   = '0;   // pos_x, pos_y, pixel_color
  logic [1:0]            in_tuser   = '0;   // op
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;         // out_byte
  logic [1:0]            out_tuser;         // is_data, window_done
  logic                  out_tlast;

  logic idle_on   = 1'b1;
  logic hold_long = 1'b0;

  int mismatches, pending, words_in, words_out, windows_done;
  int items_sent = 0;
  int cur_w      = RST_FRAME_WIDTH;
  int cur_h      = RST_FRAME_HEIGHT;
  logic [15:0] last_color = 16'h0000;

  always #5 clk = ~clk;

  dirty_window_framebuffer_scanout_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  dwfs_scanout_checker #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .mismatches   (mismatches),
    .pending      (pending),
    .words_in     (words_in),
    .words_out    (words_out),
    .windows_done (windows_done)
  );

  task automatic send_item(op_t op, logic [15:0] x, logic [15:0] y, logic [15:0] c);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {c, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op != OP_NONE) items_sent++;
  endtask

  task automatic stop_items();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_quiet();
    while (pending != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_frame(int w, int h, int co, int ro, bit wide);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_COLUMN_OFFSET, co);
    write_reg(REG_ROW_OFFSET, ro);
    write_reg(REG_EIGHTEEN_BIT, wide);
    write_reg(REG_SPARE, $urandom_range(0, 511));
    cfg_valid <= 1'b0;
    @(posedge clk);
    cur_w = w;
    cur_h = h;
  endtask

  function automatic int pick_dim();
    case ($urandom_range(0, 9))
      0:       return 1;
      1:       return 320;
      2:       return 511;
      3:       return 16;
      4:       return 0;
      default: return $urandom_range(1, 320);
    endcase
  endfunction

  function automatic int pick_offset();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic set_random_frame();
    set_frame(pick_dim(), pick_dim(), pick_offset(), pick_offset(), $urandom_range(0, 1));
  endtask

  function automatic logic [15:0] pick_color();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return last_color;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_noise();
    send_item(op_t'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom());
  endtask

  // clustered draws, a flush and roughly one next-pixel word per window pixel
  task automatic run_window();
    int ew, eh, bx, by, rw, rh, n_pix;
    logic [15:0] c;
    ew = (cur_w > MAX_W) ? MAX_W : cur_w;
    eh = (cur_h > MAX_H) ? MAX_H : cur_h;
    if (ew < 1) ew = 1;
    if (eh < 1) eh = 1;
    rw = $urandom_range(1, 4);
    rh = $urandom_range(1, 4);
    bx = $urandom_range(0, ew - 1);
    by = $urandom_range(0, eh - 1);
    repeat ($urandom_range(2, 8)) begin
      if ($urandom_range(0, 5) == 0) send_noise();
      c = pick_color();
      send_item(OP_DRAW, bx + $urandom_range(0, rw - 1), by + $urandom_range(0, rh - 1), c);
      last_color = c;
    end
    if ($urandom_range(0, 9) == 0) begin
      stop_items();
      wait_quiet();
      set_random_frame();
    end
    send_item(OP_FLUSH, $urandom(), $urandom(), $urandom());
    n_pix = rw * rh + $urandom_range(0, 3) - 1;
    if ($urandom_range(0, 7) == 0) n_pix = 1;
    if ($urandom_range(0, 9) == 0) begin
      stop_items();
      wait_quiet();
      set_random_frame();
    end
    repeat (n_pix) begin
      if ($urandom_range(0, 7) == 0) send_noise();
      send_item(OP_PIXEL, $urandom(), $urandom(), $urandom());
    end
  endtask

  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long  <= 1'b0;
        out_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int phase, target;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: nothing dirty, drops, unchanged color, flush during a scan
    send_item(OP_FLUSH, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(OP_NONE, 16'h1234, 16'h5678, 16'h9ABC);
    send_item(OP_DRAW, -1, 0, 16'hFFFF);
    send_item(OP_DRAW, 240, 0, 16'hFFFF);
    send_item(OP_DRAW, 0, 320, 16'hFFFF);
    send_item(OP_DRAW, -32768, 32767, 16'hFFFF);
    send_item(OP_DRAW, 5, 5, 16'h0000);
    send_item(OP_FLUSH, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_DRAW, 0, 0, 16'hFFFF);
    send_item(OP_DRAW, 1, 1, 16'h8001);
    send_item(OP_FLUSH, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_PIXEL, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_DRAW, 1, 0, 16'h5555);
    send_item(OP_FLUSH, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_PIXEL, 16'h0000, 16'h0000, 16'h0000);
    stop_items();
    wait_quiet();

    // oversize width, far corner, largest offsets, three-byte pixels
    set_frame(511, 320, 255, 255, 1'b1);
    send_item(OP_DRAW, 319, 319, 16'hF81F);
    send_item(OP_DRAW, 318, 318, 16'h07E0);
    send_item(OP_FLUSH, 16'h0000, 16'h0000, 16'h0000);
    repeat (4) send_item(OP_PIXEL, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_DRAW, 319, 319, 16'hF81F);
    send_item(OP_FLUSH, 16'h0000, 16'h0000, 16'h0000);
    stop_items();
    wait_quiet();

    // single pixel frame
    set_frame(1, 1, 0, 0, 1'b0);
    send_item(OP_DRAW, 0, 0, 16'hABCD);
    send_item(OP_DRAW, 1, 0, 16'h1111);
    send_item(OP_DRAW, 0, 1, 16'h2222);
    send_item(OP_FLUSH, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_PIXEL, 16'h0000, 16'h0000, 16'h0000);
    stop_items();
    wait_quiet();

    phase  = 0;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if (phase % 3 == 0) begin
        stop_items();
        wait_quiet();
        set_random_frame();
      end
      if (phase == 5) hold_long <= 1'b1;
      if (items_sent > target - RANDOM_ITEMS / 7) idle_on <= 1'b0;
      run_window();
      phase++;
    end
    stop_items();
    wait_quiet();

    $display("covered %0d input words and %0d output words over %0d completed scan windows",
             words_in, words_out, windows_done);
    $display("settings included 1x1 and oversize frames, both pixel formats and offsets 0 and 255");
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
